@@ design/mrb_pkg.sv @@
// shared types and constants for the multichannel receive ring buffer
// no dependencies

package mrb_pkg;

    localparam int DEF_CHANNELS     = 8;
    localparam int DEF_BUFFER_DEPTH = 256;
    localparam int FUNC_W           = 2;
    localparam int CHAN_W           = 3;
    localparam int BYTE_W           = 8;
    localparam int LEVEL_W          = 8;

    typedef enum logic [FUNC_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_PEEK  = 2'd2,
        OP_FLUSH = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

@@ design/mrb_ram.sv @@
// generic single-port ram with registered read
// no dependencies

module mrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ design/mrb_ctrl.sv @@
// sequencing state machine for the multichannel receive ring buffer
// depends on mrb_pkg

module mrb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    output logic          done,
    output mrb_pkg::cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = start ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_RESP;
            S_RESP:  state_next = start ? S_EXEC : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign busy     = (state_reg == S_EXEC);
    assign done     = (state_reg == S_RESP);
    assign cmd.load = start && (state_reg != S_EXEC);
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

@@ design/mrb_dpath.sv @@
// pointers, overflow flags, byte store and result registers
// depends on mrb_pkg and mrb_ram

module mrb_dpath #(
    parameter int CHANNELS     = mrb_pkg::DEF_CHANNELS,
    parameter int BUFFER_DEPTH = mrb_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mrb_pkg::cmd_t                cmd,
    input  logic [mrb_pkg::FUNC_W-1:0]   func,
    input  logic [mrb_pkg::CHAN_W-1:0]   channel,
    input  logic [mrb_pkg::BYTE_W-1:0]   rx_byte,
    output logic [mrb_pkg::BYTE_W-1:0]   read_byte,
    output logic                         read_valid,
    output logic                         push_accepted,
    output logic [mrb_pkg::LEVEL_W-1:0]  fill_level,
    output logic                         overflowed
);

    localparam int PW = $clog2(BUFFER_DEPTH);
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int AW = $clog2(CHANNELS * BUFFER_DEPTH);
    localparam int LW = (PW > mrb_pkg::LEVEL_W) ? PW : mrb_pkg::LEVEL_W;
    localparam logic [PW-1:0] PTR_LAST = PW'(BUFFER_DEPTH - 1);

    mrb_pkg::op_t                  func_reg;
    logic [mrb_pkg::CHAN_W-1:0]    chan_reg;
    logic [mrb_pkg::BYTE_W-1:0]    byte_reg;

    logic [PW-1:0]                 wp_reg [CHANNELS];
    logic [PW-1:0]                 rp_reg [CHANNELS];
    logic [CHANNELS-1:0]           ovf_reg;

    logic                          rvalid_reg;
    logic                          acc_reg;
    logic [PW-1:0]                 level_reg;
    logic                          ovf_res_reg;

    logic                          in_range;
    logic [CW-1:0]                 idx;
    logic [PW-1:0]                 wp_cur;
    logic [PW-1:0]                 rp_cur;
    logic [PW:0]                   lvl_wide;
    logic [PW-1:0]                 level;
    logic                          full;
    logic                          empty;
    logic                          do_push;
    logic                          do_read;
    logic                          do_pop;
    logic                          do_flush;
    logic [PW-1:0]                 level_after;
    logic [AW-1:0]                 ram_addr;
    logic [mrb_pkg::BYTE_W-1:0]    ram_rdata;
    logic [LW-1:0]                 level_ext;

    // input word capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= mrb_pkg::op_t'(func);
            chan_reg <= channel;
            byte_reg <= rx_byte;
        end
    end

    assign in_range = (int'(chan_reg) < CHANNELS);
    assign idx      = CW'(chan_reg);
    assign wp_cur   = in_range ? wp_reg[idx] : '0;
    assign rp_cur   = in_range ? rp_reg[idx] : '0;

    assign lvl_wide = (wp_cur >= rp_cur)
                    ? ({1'b0, wp_cur} - {1'b0, rp_cur})
                    : ({1'b0, wp_cur} + (PW+1)'(BUFFER_DEPTH) - {1'b0, rp_cur});
    assign level    = lvl_wide[PW-1:0];
    assign full     = (level == PTR_LAST);
    assign empty    = (level == '0);

    assign do_push  = in_range && (func_reg == mrb_pkg::OP_PUSH) && !full;
    assign do_read  = in_range && !empty
                      && ((func_reg == mrb_pkg::OP_POP) || (func_reg == mrb_pkg::OP_PEEK));
    assign do_pop   = do_read && (func_reg == mrb_pkg::OP_POP);
    assign do_flush = in_range && (func_reg == mrb_pkg::OP_FLUSH);

    always_comb
    begin
        if (!in_range || do_flush)
        begin
            level_after = '0;
        end
        else if (do_push)
        begin
            level_after = level + PW'(1);
        end
        else if (do_pop)
        begin
            level_after = level - PW'(1);
        end
        else
        begin
            level_after = level;
        end
    end

    // per-channel pointers and sticky flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                wp_reg[i] <= '0;
                rp_reg[i] <= '0;
            end
            ovf_reg <= '0;
        end
        else if (cmd.exec && in_range)
        begin
            if (do_flush)
            begin
                wp_reg[idx]  <= '0;
                rp_reg[idx]  <= '0;
                ovf_reg[idx] <= 1'b0;
            end
            else if (do_push)
            begin
                wp_reg[idx] <= (wp_cur == PTR_LAST) ? '0 : wp_cur + PW'(1);
            end
            else if (func_reg == mrb_pkg::OP_PUSH)
            begin
                ovf_reg[idx] <= 1'b1;
            end
            else if (do_pop)
            begin
                rp_reg[idx] <= (rp_cur == PTR_LAST) ? '0 : rp_cur + PW'(1);
            end
        end
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            rvalid_reg  <= do_read;
            acc_reg     <= do_push;
            level_reg   <= level_after;
            ovf_res_reg <= in_range && !do_flush
                           && (ovf_reg[idx] || (func_reg == mrb_pkg::OP_PUSH && full));
        end
    end

    assign ram_addr = AW'(idx) * AW'(BUFFER_DEPTH)
                    + AW'((func_reg == mrb_pkg::OP_PUSH) ? wp_cur : rp_cur);

    mrb_ram #(
        .WIDTH (mrb_pkg::BYTE_W),
        .DEPTH (CHANNELS * BUFFER_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.exec && do_push),
        .addr  (ram_addr),
        .wdata (byte_reg),
        .rdata (ram_rdata)
    );

    assign level_ext     = LW'(level_reg);
    assign read_byte     = rvalid_reg ? ram_rdata : '0;
    assign read_valid    = rvalid_reg;
    assign push_accepted = acc_reg;
    assign fill_level    = level_ext[mrb_pkg::LEVEL_W-1:0];
    assign overflowed    = ovf_res_reg;

endmodule

@@ design/multichannel_rx_ring_buffer_unit.sv @@
// top level of the multichannel receive ring buffer
// depends on mrb_pkg, mrb_ctrl, mrb_dpath and mrb_ram
//
// channel  | handshake           | word
// ---------+---------------------+-----------------------------------------------
// command  | start / busy        | func, channel, rx_byte
// result   | done (one cycle)    | read_byte, read_valid, push_accepted,
//          |                     | fill_level, overflowed
//
// a command passes through the execute state (pointer lookup and store access)
// and then the result state, which presents the result while the store's
// registered read data is out; a new command may be given in the cycle done
// is high, but a start while busy is high is not taken
// reset clears all pointers and overflow flags at once; no clearing pass
// the receiver cannot stall: each result shows for exactly one cycle

module multichannel_rx_ring_buffer_unit #(
    parameter int CHANNELS     = mrb_pkg::DEF_CHANNELS,
    parameter int BUFFER_DEPTH = mrb_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mrb_pkg::FUNC_W-1:0]   func,
    input  logic [mrb_pkg::CHAN_W-1:0]   channel,
    input  logic [mrb_pkg::BYTE_W-1:0]   rx_byte,
    output logic                         done,
    output logic [mrb_pkg::BYTE_W-1:0]   read_byte,
    output logic                         read_valid,
    output logic                         push_accepted,
    output logic [mrb_pkg::LEVEL_W-1:0]  fill_level,
    output logic                         overflowed
);

    mrb_pkg::cmd_t cmd;

    mrb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    mrb_dpath #(
        .CHANNELS     (CHANNELS),
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .func          (func),
        .channel       (channel),
        .rx_byte       (rx_byte),
        .read_byte     (read_byte),
        .read_valid    (read_valid),
        .push_accepted (push_accepted),
        .fill_level    (fill_level),
        .overflowed    (overflowed)
    );

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not enter execution");

    a_busy_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done && !busy)
        else $error("execution not followed by a result");

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result shown for more than one cycle");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(read_valid && push_accepted))
        else $error("result both read and pushed");

    a_empty_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !read_valid |-> read_byte == '0)
        else $error("read byte not zero without a valid read");

endmodule
